// ----- rtl/core/ksel_pkg.sv -----
// Shared sizes and the broadcast control bundle for the k-th smallest selector.
// Used by ksel_cell and kth_smallest_stream_select; no dependencies.
`default_nettype none

package ksel_pkg;

    localparam int N_CELLS = 64;                     // deepest rank held
    localparam int DATA_W  = 32;
    localparam int RANK_W  = 7;
    localparam int COUNT_W = $clog2(N_CELLS + 1);

    // Control broadcast to every cell for one accepted item
    typedef struct packed {
        logic                     en;      // an item is accepted this cycle
        logic                     grow;    // list not yet full: insert and lengthen
        logic signed [DATA_W-1:0] sample;  // incoming value
    } t_cell_ctl;

endpackage

`default_nettype wire

// ----- rtl/core/kth_smallest_stream_select.sv -----
// Top level: streaming k-th smallest selection over a chain of sorted cells.
// Depends on ksel_pkg and ksel_cell.
//
//  channel   direction  handshake            payload
//  s (in)    slave      i_s_tvalid/o_s_tready  tdata: sample_value; tlast: last_item
//  m (out)   master     o_m_tvalid/i_m_tready  tdata: kth_smallest; tuser: enough_items
//  cfg       write      i_cfg_we             i_cfg_wdata: rank_k
//
// One item per cycle unless stalled; the chain of 64 cells updates on each item taken.
// The result of a last item is loaded into the output register once it is free.
// Input stalls only while a result waits for that register and it is still full.
// Synchronous active-low reset clears the count, the rank (to 1) and the handshake flags.
`default_nettype none

module kth_smallest_stream_select
    import ksel_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [RANK_W-1:0] i_cfg_wdata,
    input  wire logic              i_s_tvalid,
    output logic                   o_s_tready,
    input  wire logic [DATA_W-1:0] i_s_tdata,   // [31:0] sample_value
    input  wire logic              i_s_tlast,
    output logic                   o_m_tvalid,
    input  wire logic              i_m_tready,
    output logic [DATA_W-1:0]      o_m_tdata,   // [31:0] kth_smallest
    output logic                   o_m_tuser    // [0] enough_items
);

    logic [RANK_W-1:0]  r_rank;
    logic [COUNT_W-1:0] r_count;
    logic [COUNT_W-1:0] n_count;
    logic [COUNT_W-1:0] eff_rank;
    logic               r_pend;
    logic               r_pend_enough;
    logic               r_out_valid;
    logic [DATA_W-1:0]  r_out_data;
    logic               r_out_enough;
    logic               s_acc;
    logic               out_load;
    t_cell_ctl          ctl;

    logic                     gt   [N_CELLS];
    logic signed [DATA_W-1:0] vals [N_CELLS];

    // rank 0 acts as 1, ranks above the chain length saturate
    always_comb begin
        if (r_rank == '0) begin
            eff_rank = COUNT_W'(1);
        end else if (int'(r_rank) > N_CELLS) begin
            eff_rank = COUNT_W'(N_CELLS);
        end else begin
            eff_rank = COUNT_W'(r_rank);
        end
    end

    assign out_load   = r_pend && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_pend || out_load;
    assign s_acc      = i_s_tvalid && o_s_tready;

    assign ctl.en     = s_acc;
    assign ctl.grow   = (r_count < eff_rank);
    assign ctl.sample = signed'(i_s_tdata);

    assign n_count = ctl.grow ? r_count + COUNT_W'(1) : r_count;

    for (genvar i = 0; i < N_CELLS; i++) begin : g_cell
        logic                     left_gt;
        logic signed [DATA_W-1:0] left_value;
        logic                     right_gt;
        logic signed [DATA_W-1:0] right_value;

        if (i == 0) begin : g_head
            assign left_gt    = 1'b1;
            assign left_value = '0;
        end else begin : g_mid_l
            assign left_gt    = gt[i-1];
            assign left_value = vals[i-1];
        end
        if (i == N_CELLS - 1) begin : g_tail
            assign right_gt    = 1'b0;
            assign right_value = '0;
        end else begin : g_mid_r
            assign right_gt    = gt[i+1];
            assign right_value = vals[i+1];
        end

        ksel_cell u_cell (
            .i_clk         (i_clk),
            .i_ctl         (ctl),
            .i_valid       (COUNT_W'(i) < r_count),
            .i_left_gt     (left_gt),
            .i_left_value  (left_value),
            .i_right_gt    (right_gt),
            .i_right_value (right_value),
            .o_gt          (gt[i]),
            .o_value       (vals[i])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rank      <= RANK_W'(1);
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_rank <= i_cfg_wdata;
            end
            if (s_acc) begin
                r_count <= i_s_tlast ? '0 : n_count;
            end
            if (s_acc && i_s_tlast) begin
                r_pend <= 1'b1;
            end else if (out_load) begin
                r_pend <= 1'b0;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // cell 0 holds the largest kept value once the last item has settled
    always_ff @(posedge i_clk) begin
        if (s_acc && i_s_tlast) begin
            r_pend_enough <= (n_count >= eff_rank);
        end
        if (out_load) begin
            r_out_data   <= unsigned'(vals[0]);
            r_out_enough <= r_pend_enough;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_enough;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= COUNT_W'(N_CELLS))
        else $error("kept count beyond chain length");

    a_last_pends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && i_s_tlast) |=> r_pend)
        else $error("last item did not raise a pending result");

    a_grow_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && !i_s_tlast && ctl.grow) |=> (r_count == $past(r_count) + COUNT_W'(1)))
        else $error("kept count did not advance on insert");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/ksel_cell.sv -----
// One cell of the descending sorted chain: holds one kept value.
// Depends on ksel_pkg (t_cell_ctl, DATA_W).
`default_nettype none

module ksel_cell
    import ksel_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire t_cell_ctl                i_ctl,
    input  wire logic                     i_valid,       // cell lies inside the kept list
    input  wire logic                     i_left_gt,     // neighbor toward the max end
    input  wire logic signed [DATA_W-1:0] i_left_value,
    input  wire logic                     i_right_gt,    // neighbor toward the min end
    input  wire logic signed [DATA_W-1:0] i_right_value,
    output logic                          o_gt,
    output logic signed [DATA_W-1:0]      o_value
);

    logic signed [DATA_W-1:0] r_value;
    logic signed [DATA_W-1:0] n_value;

    assign o_gt    = i_valid && (r_value > i_ctl.sample);
    assign o_value = r_value;

    // grow: values above the sample stay, the rest shift one place toward the min end.
    // replace: a smaller sample drops the max, values above it shift to the max end.
    always_comb begin
        n_value = r_value;
        if (i_ctl.grow) begin
            if (!o_gt) begin
                n_value = i_left_gt ? i_ctl.sample : i_left_value;
            end
        end else begin
            if (i_right_gt) begin
                n_value = i_right_value;
            end else if (o_gt) begin
                n_value = i_ctl.sample;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_value <= n_value;
        end
    end

endmodule

`default_nettype wire

// ----- sim/tb_kth_smallest_stream_select.sv -----
// Self-checking testbench for kth_smallest_stream_select: directed lists, then random lists
// over many rank settings, with random idling on both streams. Needs ksel_pkg and the RTL.
module tb_kth_smallest_stream_select;
    timeunit 1ns;
    timeprecision 1ps;
    import ksel_pkg::*;

    localparam int ITEM_TARGET = 1250;
    localparam int IDLE_MAX    = 14;
    localparam int SETTLE      = 4;        // idle margin at the end of each drain
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;

    typedef struct {
        logic signed [DATA_W-1:0] kth;
        logic                     enough;
    } t_kth_answer;

    // Tracks the k smallest values of the open list and queues the answer of each closed list
    class t_kth_tracker;
        logic signed [DATA_W-1:0] kept [N_CELLS];
        int unsigned              kept_n;
        logic [RANK_W-1:0]        rank;
        t_kth_answer              answers_due [$];
        int unsigned              errors;

        function new();
            rank   = 1;
            kept_n = 0;
            errors = 0;
        endfunction

        function void set_rank(logic [RANK_W-1:0] r);
            rank = r;
        endfunction

        function int unsigned pending();
            return answers_due.size();
        endfunction

        function int unsigned largest_slot();
            int unsigned best;
            best = 0;
            for (int unsigned i = 1; i < kept_n; i++) begin
                if (kept[i] > kept[best])
                    best = i;
            end
            return best;
        endfunction

        function void take_sample(logic signed [DATA_W-1:0] v, logic last);
            int unsigned k;
            int unsigned m;
            t_kth_answer ans;
            // rank zero acts as one, ranks above capacity saturate
            k = (rank == 0) ? 1 : ((rank > N_CELLS) ? N_CELLS : rank);
            if (kept_n < k) begin
                kept[kept_n] = v;
                kept_n++;
            end else begin
                m = largest_slot();
                if (v < kept[m])
                    kept[m] = v;
            end
            if (last) begin
                ans.kth    = kept[largest_slot()];
                ans.enough = (kept_n >= k);
                answers_due.push_back(ans);
                kept_n = 0;
            end
        endfunction

        function void check_answer(logic [DATA_W-1:0] data, logic user);
            t_kth_answer ans;
            if (answers_due.size() == 0) begin
                $error("unexpected result: kth_smallest %0d enough_items %0b",
                       $signed(data), user);
                errors++;
                return;
            end
            ans = answers_due.pop_front();
            if (data !== ans.kth) begin
                $error("kth_smallest: expected %0d, got %0d", ans.kth, $signed(data));
                errors++;
            end
            if (user !== ans.enough) begin
                $error("enough_items: expected %0b, got %0b", ans.enough, user);
                errors++;
            end
        endfunction
    endclass

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              cfg_we    = 1'b0;
    logic [RANK_W-1:0] cfg_wdata = '0;
    logic              s_tvalid  = 1'b0;
    logic [DATA_W-1:0] s_tdata   = '0;
    logic              s_tlast   = 1'b0;
    logic              m_tready  = 1'b0;
    logic              s_tready;
    logic              m_tvalid;
    logic [DATA_W-1:0] m_tdata;
    logic              m_tuser;

    t_kth_tracker tracker = new();
    bit          src_idle  = 1'b0;
    bit          sink_idle = 1'b0;
    int          sink_hold = 0;
    int unsigned sent_items = 0;
    int          edge_ranks [10] = '{0, 1, 2, 3, 7, 16, 63, 64, 65, 127};

    kth_smallest_stream_select dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tlast   (s_tlast),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tuser   (m_tuser)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    initial begin : watchdog
        int unsigned cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready)
            tracker.check_answer(m_tdata, m_tuser);
    end

    // Result side: per-item stall, or one long hold-off when asked
    initial begin : result_sink
        int stall;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever begin
            if (sink_hold > 0) begin
                m_tready <= 1'b0;
                repeat (sink_hold) @(negedge clk);
                sink_hold = 0;
            end else begin
                stall = sink_idle ? $urandom_range(0, IDLE_MAX) : 0;
                if (stall > 0) begin
                    m_tready <= 1'b0;
                    repeat (stall) @(negedge clk);
                end
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            @(negedge clk);
        end
    end

    // Called at a falling edge; returns at the falling edge after the item was taken
    task automatic send_item(input logic signed [DATA_W-1:0] v, input logic last);
        int gap;
        gap = src_idle ? $urandom_range(0, IDLE_MAX) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        s_tlast  <= last;
        do @(posedge clk); while (!s_tready);
        tracker.take_sample(v, last);
        sent_items++;
        @(negedge clk);
    endtask

    // Stop sending and let every outstanding result arrive
    task automatic drain();
        s_tvalid <= 1'b0;
        while (tracker.pending() != 0) @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_rank(input logic [RANK_W-1:0] r);
        cfg_wdata <= r;
        cfg_we    <= 1'b1;
        @(negedge clk);
        cfg_we    <= 1'b0;
        tracker.set_rank(r);
    endtask

    initial begin : stimulus
        int                       rank_pick;
        int                       k_eff;
        int                       n_lists;
        int                       len;
        int                       mode;
        logic signed [DATA_W-1:0] val;

        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: extremes, ties, short lists, rank bounds, rank change mid-list
        send_item(32'h8000_0000, 1'b1);
        send_item(32'h7FFF_FFFF, 1'b0);
        send_item(-1, 1'b0);
        send_item(0, 1'b1);
        drain();
        write_rank(0);
        send_item(5, 1'b0);
        send_item(5, 1'b1);
        drain();
        write_rank(3);
        send_item(10, 1'b0);
        send_item(20, 1'b1);
        send_item(3, 1'b0);
        send_item(3, 1'b0);
        send_item(3, 1'b0);
        send_item(3, 1'b1);
        drain();
        write_rank(127);
        send_item(1, 1'b0);
        send_item(2, 1'b1);
        drain();
        write_rank(4);
        send_item(9, 1'b0);
        send_item(8, 1'b0);
        send_item(7, 1'b0);
        send_item(6, 1'b0);
        drain();
        write_rank(2);
        send_item(1, 1'b1);
        send_item(50, 1'b0);
        drain();
        write_rank(5);
        send_item(40, 1'b0);
        send_item(30, 1'b1);
        drain();

        // Long output hold-off while single-item lists keep coming
        write_rank(1);
        sink_hold = HOLD_CYCLES;
        for (int i = 0; i < 30; i++)
            send_item($urandom, 1'b1);
        drain();

        while (sent_items < ITEM_TARGET) begin
            rank_pick = $urandom_range(0, 1) ? $urandom_range(0, 127)
                                             : edge_ranks[$urandom_range(0, 9)];
            drain();
            write_rank(RANK_W'(rank_pick));
            k_eff     = (rank_pick == 0) ? 1 : ((rank_pick > N_CELLS) ? N_CELLS : rank_pick);
            src_idle  = ($urandom_range(0, 3) != 0);
            sink_idle = ($urandom_range(0, 3) != 0);
            n_lists   = $urandom_range(2, 8);
            for (int l = 0; l < n_lists && sent_items < ITEM_TARGET; l++) begin
                len  = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 3)
                                                   : $urandom_range(1, 2 * k_eff + 4);
                mode = $urandom_range(0, 3);
                for (int i = 0; i < len; i++) begin
                    case (mode)
                        0, 1: val = $urandom;
                        2:    val = $signed($urandom_range(0, 8)) - 4;   // many ties
                        default: begin
                            case ($urandom_range(0, 3))
                                0:       val = 32'h7FFF_FFFF;
                                1:       val = 32'h8000_0000;
                                2:       val = 0;
                                default: val = $urandom;
                            endcase
                        end
                    endcase
                    send_item(val, i == len - 1);
                end
            end
            // sometimes leave a list open across the next rank write
            if ($urandom_range(0, 3) == 0) begin
                len = $urandom_range(1, 5);
                for (int i = 0; i < len; i++)
                    send_item($urandom, 1'b0);
            end
        end

        drain();
        repeat (10) @(negedge clk);
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
